// ===== rtl/bpmc_pkg.sv =====
// types and constants shared by the byte pattern match counter
// no dependencies
`default_nettype none

package bpmc_pkg;

	localparam int COUNT_W     = 48;
	localparam int POS_W       = 48;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int LEN_W       = 5;
	localparam int PAT_BYTES   = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [POS_W-1:0]   POS_MAX   = {POS_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LO  = 2'd0,
		REG_PAT_HI  = 2'd1,
		REG_PAT_LEN = 2'd2,
		REG_LIMIT   = 2'd3
	} cfg_reg_t;

	// one classified byte passed from front to back
	typedef struct packed {
		logic hit;
		logic last;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// ===== rtl/bpmc_front.sv =====
// front part: config registers, byte history, position counter and pattern compare
// depends on bpmc_pkg
`default_nettype none

module bpmc_front #(
	parameter int MAX_PATTERN = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bpmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bpmc_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [7:0]                     s_tdata,
	input  wire logic                           s_tlast,
	input  bpmc_pkg::q_status_t                 q_status,
	output logic                                push,
	output bpmc_pkg::entry_t                    push_entry
);
	import bpmc_pkg::*;

	localparam int HIST_DEPTH = MAX_PATTERN - 1;

	logic [CFG_W-1:0] pat_lo_q;
	logic [CFG_W-1:0] pat_hi_q;
	logic [LEN_W-1:0] pat_len_q;
	logic [POS_W-1:0] limit_q;
	logic [POS_W-1:0] seen_q;
	logic [7:0]       hist_q [HIST_DEPTH];

	logic [LEN_W-1:0]       len;
	logic [LEN_W-1:0]       len_m1;
	logic [8*PAT_BYTES-1:0] pat;
	logic [7:0]             win [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] byte_ok;
	logic                   long_enough;
	logic                   limit_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= LEN_W'(1);
			limit_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PAT_LO:  pat_lo_q  <= cfg_data;
				REG_PAT_HI:  pat_hi_q  <= cfg_data;
				REG_PAT_LEN: pat_len_q <= cfg_data[LEN_W-1:0];
				REG_LIMIT:   limit_q   <= cfg_data[POS_W-1:0];
			endcase
		end
	end

	always_comb begin
		if (pat_len_q == '0) begin
			len = LEN_W'(1);
		end else if (pat_len_q > LEN_W'(MAX_PATTERN)) begin
			len = LEN_W'(MAX_PATTERN);
		end else begin
			len = pat_len_q;
		end
		len_m1 = len - LEN_W'(1);
		pat    = {pat_hi_q, pat_lo_q};
	end

	// newest byte at window position 0, compared against pattern byte len-1-k
	always_comb begin
		logic [LEN_W-1:0] idx;
		win[0] = s_tdata;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			win[k] = hist_q[k-1];
		end
		for (int k = 0; k < MAX_PATTERN; k++) begin
			idx = len_m1 - LEN_W'(k);
			if (LEN_W'(k) < len) begin
				byte_ok[k] = (win[k] == pat[{idx[3:0], 3'b000} +: 8]);
			end else begin
				byte_ok[k] = 1'b1;
			end
		end
	end

	// position after this byte is seen_q+1, saturating
	assign long_enough = (seen_q >= {{(POS_W-LEN_W){1'b0}}, len_m1});
	assign limit_ok    = (limit_q == '0) || (seen_q < limit_q)
	                     || ((seen_q == POS_MAX) && (limit_q == POS_MAX));

	assign s_tready        = !q_status.full;
	assign push            = s_tvalid && s_tready;
	assign push_entry.hit  = long_enough && limit_ok && (&byte_ok);
	assign push_entry.last = s_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int k = 0; k < HIST_DEPTH; k++) begin
				hist_q[k] <= '0;
			end
		end else if (push) begin
			if (s_tlast) begin
				seen_q <= '0;
				for (int k = 0; k < HIST_DEPTH; k++) begin
					hist_q[k] <= '0;
				end
			end else begin
				if (seen_q != POS_MAX) begin
					seen_q <= seen_q + POS_W'(1);
				end
				hist_q[0] <= s_tdata;
				for (int k = 1; k < HIST_DEPTH; k++) begin
					hist_q[k] <= hist_q[k-1];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bpmc_queue.sv =====
// short queue of classified bytes between front and back
// depends on bpmc_pkg
`default_nettype none

module bpmc_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  bpmc_pkg::entry_t   push_entry,
	input  wire logic          pop,
	output bpmc_pkg::entry_t   head,
	output bpmc_pkg::q_status_t status
);
	import bpmc_pkg::*;

	entry_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W:0]   wr_ptr_q;
	logic [QPTR_W:0]   rd_ptr_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q[QPTR_W-1:0]] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + (QPTR_W+1)'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + (QPTR_W+1)'(1);
			end
		end
	end

	assign head         = slot_q[rd_ptr_q[QPTR_W-1:0]];
	assign status.empty = (wr_ptr_q == rd_ptr_q);
	assign status.full  = (wr_ptr_q[QPTR_W] != rd_ptr_q[QPTR_W])
	                      && (wr_ptr_q[QPTR_W-1:0] == rd_ptr_q[QPTR_W-1:0]);

endmodule

`default_nettype wire

// ===== rtl/bpmc_back.sv =====
// back part: saturating match count and result register
// depends on bpmc_pkg
`default_nettype none

module bpmc_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  bpmc_pkg::entry_t                  head,
	input  bpmc_pkg::q_status_t               q_status,
	output logic                              pop,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [bpmc_pkg::COUNT_W-1:0]      m_tdata,
	output logic                              m_tuser
);
	import bpmc_pkg::*;

	logic [COUNT_W-1:0] cnt_q;
	logic               sat_q;
	logic               out_valid_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_sat_q;

	logic [COUNT_W-1:0] cnt_next;
	logic               sat_next;
	logic               load;

	always_comb begin
		cnt_next = cnt_q;
		if (head.hit && (cnt_q != COUNT_MAX)) begin
			cnt_next = cnt_q + COUNT_W'(1);
		end
		sat_next = sat_q || (head.hit && (cnt_q >= COUNT_MAX - COUNT_W'(1)));
	end

	assign pop  = !q_status.empty && (!head.last || !out_valid_q || m_tready);
	assign load = pop && head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head.last) begin
					cnt_q <= '0;
					sat_q <= 1'b0;
				end else begin
					cnt_q <= cnt_next;
					sat_q <= sat_next;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_count_q <= cnt_next;
			out_sat_q   <= sat_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_count_q;
	assign m_tuser  = out_sat_q;

endmodule

`default_nettype wire

// ===== rtl/byte_pattern_match_counter_core.sv =====
// byte pattern match counter: counts overlapping occurrences of a 1 to 16 byte
// pattern in a byte stream; instantiates bpmc_front, bpmc_queue, bpmc_back
// depends on bpmc_pkg
//
// usage
//   slave stream: one object byte per transaction, tlast on the final byte
//   master stream: one transaction per object, sent after its final byte;
//     tdata is the match count, tuser is set when the count saturated
//   config port: write pattern low/high bytes, pattern length and byte limit
//     while no object is in flight; a limit of 0 counts the whole object
// throughput: one byte per cycle while the queue is not full; the pattern
//   compare over the history is done in parallel in the front part
// result path: the final byte is written into the queue; m_tvalid rises
//   when the back part pops it from there and loads the result register
// stall: a held result stops the back part at the next final byte; the
//   four-entry queue then fills and s_tready drops
// reset: config returns to pattern zero, length 1, no limit; history and
//   counters clear, no result pending
`default_nettype none

module byte_pattern_match_counter_core #(
	parameter int MAX_PATTERN = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bpmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bpmc_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [7:0]                     s_tdata,  // data_byte
	input  wire logic                           s_tlast,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [bpmc_pkg::COUNT_W-1:0]        m_tdata,  // occurrence count
	output logic                                m_tuser   // count_saturated
);
	import bpmc_pkg::*;

	q_status_t q_status;
	entry_t    push_entry;
	entry_t    head;
	logic      push;
	logic      pop;

	bpmc_front #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	bpmc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	bpmc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire
